### design/rde_pkg.sv
`timescale 1ns / 1ps

package rde_pkg;

  localparam int ALPHA_DEPTH = 128;
  localparam int DIGIT_SLOTS = 32;

  localparam int NUM_W      = 32;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = $clog2(ALPHA_DEPTH + 1);
  localparam int ADDR_W     = $clog2(ALPHA_DEPTH);
  localparam int RADIX_W    = 8;
  localparam int DIGIT_W    = 7;
  localparam int DIG_ADDR_W = $clog2(DIGIT_SLOTS);
  localparam int DIG_CNT_W  = $clog2(DIGIT_SLOTS + 1);
  localparam int SEEN_W     = 128;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = NUM_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_LO    = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HI    = 8'd126;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CONV = 1'b1;

  typedef enum logic {
    CMD_LOAD,
    CMD_CONV
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                neg;
    logic [NUM_W-1:0]    mag;
    logic [RADIX_W-1:0]  radix;
    logic [ADDR_W-1:0]   addr;
    logic [CHAR_W-1:0]   sym;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

### design/rde_ram.sv
`timescale 1ns / 1ps

module rde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/rde_front.sv
`timescale 1ns / 1ps

module rde_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           req_type,
  input  logic [rde_pkg::CHAR_W-1:0]     symbol,
  input  logic                           symbol_last,
  input  logic signed [rde_pkg::NUM_W-1:0] number,
  output logic                           push,
  output rde_pkg::cmd_t                  cmd
);

  logic [rde_pkg::LEN_W-1:0]  len;
  logic [rde_pkg::SEEN_W-1:0] seen;
  logic                       bad;
  logic                       ready;
  logic                       closed;

  logic [rde_pkg::LEN_W-1:0]  len_base;
  logic [rde_pkg::SEEN_W-1:0] seen_base;
  logic                       bad_base;
  logic                       range_bad;
  logic                       dup;
  logic                       full;
  logic [rde_pkg::LEN_W-1:0]  len_next;
  logic [rde_pkg::SEEN_W-1:0] seen_next;
  logic                       bad_next;
  logic [rde_pkg::NUM_W-1:0]  num_u;

  always_comb begin
    len_base  = closed ? '0 : len;
    seen_base = closed ? '0 : seen;
    bad_base  = closed ? 1'b0 : bad;
    range_bad = (symbol == rde_pkg::CHAR_PLUS) || (symbol == rde_pkg::CHAR_MINUS) ||
                (symbol < rde_pkg::CHAR_LO) || (symbol > rde_pkg::CHAR_HI);
    // codes of 128 and up are out of range, so the map covers the low half only
    dup       = !symbol[7] && seen_base[symbol[6:0]];
    full      = (len_base == rde_pkg::LEN_W'(rde_pkg::ALPHA_DEPTH));
    len_next  = full ? len_base : len_base + rde_pkg::LEN_W'(1);
    bad_next  = bad_base || range_bad || dup || full;
    seen_next = seen_base;
    if (!symbol[7]) begin
      seen_next[symbol[6:0]] = 1'b1;
    end
  end

  always_comb begin
    num_u     = number;
    cmd.kind  = (req_type == rde_pkg::REQ_LOAD) ? rde_pkg::CMD_LOAD : rde_pkg::CMD_CONV;
    cmd.neg   = num_u[rde_pkg::NUM_W-1];
    cmd.mag   = num_u[rde_pkg::NUM_W-1] ? (rde_pkg::NUM_W'(0) - num_u) : num_u;
    cmd.radix = rde_pkg::RADIX_W'(len);
    cmd.addr  = len_base[rde_pkg::ADDR_W-1:0];
    cmd.sym   = symbol;
    push      = accept && (((req_type == rde_pkg::REQ_LOAD) && !full) ||
                           ((req_type == rde_pkg::REQ_CONV) && ready));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= '0;
      seen   <= '0;
      bad    <= 1'b0;
      ready  <= 1'b0;
      closed <= 1'b1;
    end else if (accept && (req_type == rde_pkg::REQ_LOAD)) begin
      len    <= len_next;
      seen   <= seen_next;
      bad    <= bad_next;
      ready  <= symbol_last && (len_next >= rde_pkg::LEN_W'(2)) && !bad_next;
      closed <= symbol_last;
    end
  end

endmodule

### design/rde_cmd_fifo.sv
`timescale 1ns / 1ps

module rde_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rde_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output rde_pkg::cmd_t       head,
  output rde_pkg::fifo_stat_t stat
);

  rde_pkg::cmd_t                     slots [rde_pkg::FIFO_DEPTH];
  logic [rde_pkg::FIFO_PTR_W-1:0]    wptr;
  logic [rde_pkg::FIFO_PTR_W-1:0]    rptr;
  logic [rde_pkg::FIFO_CNT_W-1:0]    count;
  logic                              do_push;
  logic                              do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == rde_pkg::FIFO_CNT_W'(rde_pkg::FIFO_DEPTH));
  assign head       = slots[rptr];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + rde_pkg::FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + rde_pkg::FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + rde_pkg::FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - rde_pkg::FIFO_CNT_W'(1);
      end
    end
  end

endmodule

### design/rde_back.sv
`timescale 1ns / 1ps

module rde_back (
  input  logic                       clk,
  input  logic                       rst,
  input  rde_pkg::cmd_t              head,
  input  rde_pkg::fifo_stat_t        stat,
  output logic                       pop,
  output logic                       strobe,
  output logic [rde_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD_DIG,
    S_RD_SYM,
    S_OUT
  } state_t;

  state_t                          state;
  logic [rde_pkg::NUM_W-1:0]       quo;
  logic [rde_pkg::DIGIT_W-1:0]     rem;
  logic [rde_pkg::RADIX_W-1:0]     radix;
  logic [rde_pkg::DIV_CNT_W-1:0]   step;
  logic [rde_pkg::DIG_CNT_W-1:0]   n;

  logic [rde_pkg::NUM_W-1:0]       quo_next;
  logic [rde_pkg::DIGIT_W-1:0]     rem_next;
  logic [rde_pkg::DIGIT_W:0]       cand;
  logic                            digit_done;
  logic [rde_pkg::DIG_CNT_W-1:0]   n_dec;

  logic                            tab_we;
  logic [rde_pkg::ADDR_W-1:0]      tab_raddr;
  logic [rde_pkg::CHAR_W-1:0]      tab_rdata;
  logic                            dig_we;
  logic [rde_pkg::DIGIT_W-1:0]     dig_rdata;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    quo_next = quo;
    rem_next = rem;
    cand     = '0;
    for (int i = 0; i < rde_pkg::DIV_BITS; i++) begin
      cand     = {rem_next, quo_next[rde_pkg::NUM_W-1]};
      quo_next = {quo_next[rde_pkg::NUM_W-2:0], 1'b0};
      if (cand >= radix) begin
        rem_next    = rde_pkg::DIGIT_W'(cand - radix);
        quo_next[0] = 1'b1;
      end else begin
        rem_next = cand[rde_pkg::DIGIT_W-1:0];
      end
    end
  end

  assign digit_done = (state == S_DIV) && (step == rde_pkg::DIV_CNT_W'(rde_pkg::DIV_CYCLES - 1));
  assign pop        = (state == S_IDLE) && !stat.empty;
  assign tab_we     = pop && (head.kind == rde_pkg::CMD_LOAD);
  assign dig_we     = digit_done;
  assign n_dec      = n - rde_pkg::DIG_CNT_W'(1);
  assign tab_raddr  = rde_pkg::ADDR_W'(dig_rdata);

  rde_ram #(
    .WIDTH(rde_pkg::CHAR_W),
    .DEPTH(rde_pkg::ALPHA_DEPTH)
  ) u_alpha (
    .clk  (clk),
    .we   (tab_we),
    .waddr(head.addr),
    .wdata(head.sym),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  rde_ram #(
    .WIDTH(rde_pkg::DIGIT_W),
    .DEPTH(rde_pkg::DIGIT_SLOTS)
  ) u_digits (
    .clk  (clk),
    .we   (dig_we),
    .waddr(n[rde_pkg::DIG_ADDR_W-1:0]),
    .wdata(rem_next),
    .raddr(n_dec[rde_pkg::DIG_ADDR_W-1:0]),
    .rdata(dig_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      strobe   <= 1'b0;
      out_char <= '0;
      out_last <= 1'b0;
      quo      <= '0;
      rem      <= '0;
      radix    <= '0;
      step     <= '0;
      n        <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop && (head.kind == rde_pkg::CMD_CONV)) begin
            quo   <= head.mag;
            rem   <= '0;
            radix <= head.radix;
            step  <= '0;
            n     <= '0;
            state <= S_DIV;
            if (head.neg) begin
              strobe   <= 1'b1;
              out_char <= rde_pkg::CHAR_MINUS;
              out_last <= 1'b0;
            end
          end
        end
        S_DIV: begin
          quo  <= quo_next;
          rem  <= rem_next;
          step <= step + rde_pkg::DIV_CNT_W'(1);
          if (digit_done) begin
            rem  <= '0;
            step <= '0;
            n    <= n + rde_pkg::DIG_CNT_W'(1);
            // zero still yields one digit
            if (quo_next == '0) begin
              state <= S_RD_DIG;
            end
          end
        end
        S_RD_DIG: begin
          n     <= n_dec;
          state <= S_RD_SYM;
        end
        S_RD_SYM: begin
          state <= S_OUT;
        end
        S_OUT: begin
          strobe   <= 1'b1;
          out_char <= tab_rdata;
          out_last <= (n == '0);
          state    <= (n == '0) ? S_IDLE : S_RD_DIG;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/radix_digit_emitter.sv
`timescale 1ns / 1ps

// Writes a signed 32-bit number in the base set by a loaded symbol alphabet.
// Input: an item is taken on a rising edge with start high and busy low.
//   req_type 0 loads one alphabet symbol (symbol_last closes the alphabet);
//   req_type 1 converts number. Loads give no output.
// Output: each character is held for one cycle and marked by strobe, out_last
//   on the final one; the receiver must take each character as it appears.
// Items enter a four-entry command queue; busy is high only while it is
//   full, so loads are taken one per cycle until then.
// A conversion at the head of the queue: a negative number first gives the
//   minus sign, registered in the cycle after the pop; then each digit comes
//   from the shared divider (8 quotient bits per cycle), and each character
//   takes two registered memory reads, digit memory then alphabet table.
// An invalid, unfinished or missing alphabet makes a convert item give nothing.
// Reset (rst, synchronous) empties the queue and leaves no valid alphabet.
module radix_digit_emitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type,
  input  logic [rde_pkg::CHAR_W-1:0]       symbol,
  input  logic                             symbol_last,
  input  logic signed [rde_pkg::NUM_W-1:0] number,
  output logic                             strobe,
  output logic [rde_pkg::CHAR_W-1:0]       out_char,
  output logic                             out_last
);

  rde_pkg::cmd_t       push_cmd;
  rde_pkg::cmd_t       head;
  rde_pkg::fifo_stat_t stat;
  logic                push;
  logic                pop;
  logic                accept;

  assign busy   = stat.full;
  assign accept = start && !busy;

  rde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req_type),
    .symbol     (symbol),
    .symbol_last(symbol_last),
    .number     (number),
    .push       (push),
    .cmd        (push_cmd)
  );

  rde_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .stat    (stat)
  );

  rde_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .stat    (stat),
    .pop     (pop),
    .strobe  (strobe),
    .out_char(out_char),
    .out_last(out_last)
  );

endmodule

### design/rde_checker.sv
`timescale 1ns / 1ps

module rde_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             req_type,
  input logic [rde_pkg::CHAR_W-1:0]       symbol,
  input logic                             symbol_last,
  input logic signed [rde_pkg::NUM_W-1:0] number,
  input logic                             strobe,
  input logic [rde_pkg::CHAR_W-1:0]       out_char,
  input logic                             out_last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("output or busy active after reset");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (out_char == rde_pkg::CHAR_MINUS) |-> !out_last)
    else $error("minus sign closed a conversion");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe && (out_char != rde_pkg::CHAR_MINUS) |->
      (out_char >= rde_pkg::CHAR_LO) && (out_char <= rde_pkg::CHAR_HI) &&
      (out_char != rde_pkg::CHAR_PLUS))
    else $error("emitted symbol outside a valid alphabet");

  a_gap_within_item: assert property (@(posedge clk) disable iff (rst)
    strobe && !out_last |=> !strobe)
    else $error("characters of one conversion back to back");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (.*);
